// ----- sv/fhp_pkg.sv -----
// Types, status codes, phase encoding and decode tables for the frame header parser.
// No dependencies; imported by the channel interfaces and every module.
package fhp_pkg;

	localparam logic [3:0] STS_OK       = 4'd0;
	localparam logic [3:0] STS_SYNC     = 4'd1;
	localparam logic [3:0] STS_RESERVED = 4'd2;
	localparam logic [3:0] STS_CHANNEL  = 4'd3;
	localparam logic [3:0] STS_DEPTH    = 4'd4;
	localparam logic [3:0] STS_CODED    = 4'd5;
	localparam logic [3:0] STS_INDEX    = 4'd6;
	localparam logic [3:0] STS_BLOCK    = 4'd7;
	localparam logic [3:0] STS_RATE     = 4'd8;
	localparam logic [3:0] STS_CRC      = 4'd9;

	localparam logic [7:0] SYNC_FIRST  = 8'hFF;
	localparam logic [5:0] SYNC_SECOND = 6'h3E;
	localparam logic [7:0] CRC_POLY    = 8'h07;
	localparam logic [3:0] CHAN_MAX    = 4'd10;
	localparam logic [3:0] CHAN_STEREO = 4'd8;
	localparam logic [3:0] RATE_KHZ    = 4'd12;
	localparam logic [3:0] RATE_HZ     = 4'd13;
	localparam logic [3:0] RATE_DAHZ   = 4'd14;
	localparam logic [3:0] RATE_BAD    = 4'd15;
	localparam logic [3:0] BLOCK_X8    = 4'd6;
	localparam logic [3:0] BLOCK_X16   = 4'd7;
	localparam int         KHZ_SCALE   = 1000;
	localparam int         DAHZ_SCALE  = 10;
	localparam int         INDEX_BITS  = 31;

	typedef enum logic [8:0] {
		PH_IDLE = 9'b000000001,
		PH_B1   = 9'b000000010,
		PH_B2   = 9'b000000100,
		PH_B3   = 9'b000001000,
		PH_POS  = 9'b000010000,
		PH_POSC = 9'b000100000,
		PH_BSX  = 9'b001000000,
		PH_RSX  = 9'b010000000,
		PH_CRC  = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic       start_req;
		logic [7:0] header_byte;
	} step_t;

	typedef struct packed {
		logic [3:0]  status;
		logic        variable_blocking;
		logic [35:0] position;
		logic [16:0] block_size;
		logic [19:0] sample_rate;
		logic [3:0]  channel_assignment;
		logic [3:0]  channel_count;
		logic [4:0]  sample_depth;
	} result_t;

	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic logic [3:0] lead_ones(input logic [7:0] b);
		logic [3:0] n;
		logic       run;
		n   = 4'd0;
		run = 1'b1;
		for (int i = 7; i >= 0; i--) begin
			run = run & b[i];
			n   = n + {3'b000, run};
		end
		return n;
	endfunction

	function automatic logic [4:0] depth_lookup(input logic [2:0] code);
		logic [4:0] d;
		case (code)
			3'd1:    d = 5'd8;
			3'd2:    d = 5'd12;
			3'd4:    d = 5'd16;
			3'd5:    d = 5'd20;
			3'd6:    d = 5'd24;
			default: d = 5'd0;
		endcase
		return d;
	endfunction

	function automatic logic [16:0] bsize_lookup(input logic [3:0] code);
		logic [16:0] s;
		case (code)
			4'd1:    s = 17'd192;
			4'd2:    s = 17'd576;
			4'd3:    s = 17'd1152;
			4'd4:    s = 17'd2304;
			4'd5:    s = 17'd4608;
			4'd8:    s = 17'd256;
			4'd9:    s = 17'd512;
			4'd10:   s = 17'd1024;
			4'd11:   s = 17'd2048;
			4'd12:   s = 17'd4096;
			4'd13:   s = 17'd8192;
			4'd14:   s = 17'd16384;
			4'd15:   s = 17'd32768;
			default: s = 17'd0;
		endcase
		return s;
	endfunction

	function automatic logic [19:0] rate_lookup(input logic [3:0] code);
		logic [19:0] r;
		case (code)
			4'd1:    r = 20'd88200;
			4'd2:    r = 20'd176400;
			4'd3:    r = 20'd192000;
			4'd4:    r = 20'd8000;
			4'd5:    r = 20'd16000;
			4'd6:    r = 20'd22050;
			4'd7:    r = 20'd24000;
			4'd8:    r = 20'd32000;
			4'd9:    r = 20'd44100;
			4'd10:   r = 20'd48000;
			4'd11:   r = 20'd96000;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

	function automatic logic [19:0] rate_calc(input logic [3:0] code, input logic [16:0] extra);
		logic [26:0] prod;
		logic [19:0] r;
		prod = 27'(extra) * 27'(KHZ_SCALE);
		case (code)
			RATE_KHZ:  r = prod[19:0];
			RATE_HZ:   r = {3'd0, extra};
			RATE_DAHZ: r = 20'(27'(extra) * 27'(DAHZ_SCALE));
			default:   r = rate_lookup(code);
		endcase
		return r;
	endfunction

endpackage

// ----- sv/fhp_byte_if.sv -----
// Input channel: one header byte per word, with the start flag.
// Depends on fhp_pkg.
interface fhp_byte_if;
	import fhp_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic       start_req;

	modport source (output valid, output header_byte, output start_req, input ready);
	modport sink (input valid, input header_byte, input start_req, output ready);
endinterface

// ----- sv/fhp_result_if.sv -----
// Output channel: one decoded header result per word.
// Depends on fhp_pkg.
interface fhp_result_if;
	import fhp_pkg::*;

	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic        variable_blocking;
	logic [35:0] position;
	logic [16:0] block_size;
	logic [19:0] sample_rate;
	logic [3:0]  channel_assignment;
	logic [3:0]  channel_count;
	logic [4:0]  sample_depth;

	modport source (output valid, output status, output variable_blocking, output position,
		output block_size, output sample_rate, output channel_assignment,
		output channel_count, output sample_depth, input ready);
	modport sink (input valid, input status, input variable_blocking, input position,
		input block_size, input sample_rate, input channel_assignment,
		input channel_count, input sample_depth, output ready);
endinterface

// ----- sv/fhp_parse.sv -----
// Header parse state and single-byte step logic: phase, fields, CRC-8.
// Depends on fhp_pkg.
module fhp_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  fhp_pkg::step_t  step,
	output logic            res_valid,
	output fhp_pkg::result_t res
);
	import fhp_pkg::*;

	phase_t      phase_q, phase_n;
	logic [2:0]  bl_q, bl_n;
	logic [35:0] pos_q, pos_n;
	logic        strat_q, strat_n;
	logic [3:0]  block_q, block_n;
	logic [3:0]  rate_q, rate_n;
	logic [3:0]  chan_q, chan_n;
	logic [4:0]  depth_q, depth_n;
	logic [16:0] extra_q, extra_n;
	logic [16:0] size_q, size_n;
	logic [7:0]  crc_q, crc_n;

	logic        err;
	logic [3:0]  err_code;
	logic        go_pos;
	logic        go_blk;
	logic        ok;
	logic [3:0]  ones;
	logic [7:0]  data;

	assign data = step.header_byte;

	always_comb begin
		phase_n  = phase_q;
		bl_n     = bl_q;
		pos_n    = pos_q;
		strat_n  = strat_q;
		block_n  = block_q;
		rate_n   = rate_q;
		chan_n   = chan_q;
		depth_n  = depth_q;
		extra_n  = extra_q;
		size_n   = size_q;
		crc_n    = crc_q;
		err      = 1'b0;
		err_code = STS_OK;
		go_pos   = 1'b0;
		go_blk   = 1'b0;
		ok       = 1'b0;
		ones     = lead_ones(data);
		res_valid = 1'b0;
		res       = '0;

		if (step.start_req) begin
			phase_n = PH_B1;
			bl_n    = 3'd0;
			pos_n   = '0;
			strat_n = 1'b0;
			block_n = 4'd0;
			rate_n  = 4'd0;
			chan_n  = 4'd0;
			depth_n = 5'd0;
			size_n  = '0;
			extra_n = {9'd0, data};
			crc_n   = crc8_next(8'h00, data);
		end else if (phase_q != PH_IDLE) begin
			if (phase_q != PH_CRC) begin
				crc_n = crc8_next(crc_q, data);
			end
			case (phase_q)
				PH_B1: begin
					if (extra_q != {9'd0, SYNC_FIRST} || data[7:2] != SYNC_SECOND) begin
						err = 1'b1; err_code = STS_SYNC;
					end else if (data[1]) begin
						err = 1'b1; err_code = STS_RESERVED;
					end else begin
						strat_n = data[0];
						phase_n = PH_B2;
					end
				end
				PH_B2: begin
					block_n = data[7:4];
					rate_n  = data[3:0];
					phase_n = PH_B3;
				end
				PH_B3: begin
					chan_n = data[7:4];
					if (data[7:4] > CHAN_MAX) begin
						err = 1'b1; err_code = STS_CHANNEL;
					end else if (data[3:1] == 3'd3 || data[3:1] == 3'd7) begin
						err = 1'b1; err_code = STS_DEPTH;
					end else if (data[0]) begin
						depth_n = depth_lookup(data[3:1]);
						err = 1'b1; err_code = STS_RESERVED;
					end else begin
						depth_n = depth_lookup(data[3:1]);
						phase_n = PH_POS;
					end
				end
				PH_POS: begin
					if (ones == 4'd0) begin
						pos_n  = {28'd0, data};
						go_pos = 1'b1;
					end else if (ones == 4'd1 || ones == 4'd8) begin
						err = 1'b1; err_code = STS_CODED;
					end else begin
						pos_n   = {28'd0, data & (8'h7F >> ones)};
						bl_n    = 3'(ones - 4'd1);
						phase_n = PH_POSC;
					end
				end
				PH_POSC: begin
					if (data[7:6] != 2'b10) begin
						err = 1'b1; err_code = STS_CODED;
					end else begin
						pos_n = {pos_q[29:0], data[5:0]};
						bl_n  = bl_q - 3'd1;
						go_pos = (bl_n == 3'd0);
					end
				end
				PH_BSX: begin
					extra_n = {extra_q[8:0], data};
					bl_n    = bl_q - 3'd1;
					if (bl_n == 3'd0) begin
						size_n = extra_n + 17'd1;
						go_blk = 1'b1;
					end
				end
				PH_RSX: begin
					extra_n = {extra_q[8:0], data};
					bl_n    = bl_q - 3'd1;
					if (bl_n == 3'd0) begin
						phase_n = PH_CRC;
					end
				end
				PH_CRC: begin
					if (data != crc_q) begin
						err = 1'b1; err_code = STS_CRC;
					end else begin
						ok = 1'b1;
					end
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase

			if (go_pos) begin
				if (!strat_q && pos_n[35:INDEX_BITS] != '0) begin
					err = 1'b1; err_code = STS_INDEX;
				end else if (block_q == 4'd0) begin
					err = 1'b1; err_code = STS_BLOCK;
				end else begin
					extra_n = '0;
					if (block_q == BLOCK_X8 || block_q == BLOCK_X16) begin
						bl_n    = (block_q == BLOCK_X8) ? 3'd1 : 3'd2;
						phase_n = PH_BSX;
					end else begin
						size_n = bsize_lookup(block_q);
						go_blk = 1'b1;
					end
				end
			end

			if (go_blk) begin
				extra_n = '0;
				if (rate_q == RATE_BAD) begin
					err = 1'b1; err_code = STS_RATE;
				end else if (rate_q == RATE_KHZ) begin
					bl_n    = 3'd1;
					phase_n = PH_RSX;
				end else if (rate_q == RATE_HZ || rate_q == RATE_DAHZ) begin
					bl_n    = 3'd2;
					phase_n = PH_RSX;
				end else begin
					phase_n = PH_CRC;
				end
			end

			if (err) begin
				res_valid  = 1'b1;
				res.status = err_code;
				phase_n    = PH_IDLE;
			end else if (ok) begin
				res_valid              = 1'b1;
				res.status             = STS_OK;
				res.variable_blocking  = strat_q;
				res.position           = pos_q;
				res.block_size         = size_q;
				res.sample_rate        = rate_calc(rate_q, extra_q);
				res.channel_assignment = chan_q;
				res.channel_count      = (chan_q < CHAN_STEREO) ? chan_q + 4'd1 : 4'd2;
				res.sample_depth       = depth_q;
				phase_n                = PH_IDLE;
			end
		end

		if (!step.valid) begin
			phase_n   = phase_q;
			bl_n      = bl_q;
			pos_n     = pos_q;
			strat_n   = strat_q;
			block_n   = block_q;
			rate_n    = rate_q;
			chan_n    = chan_q;
			depth_n   = depth_q;
			extra_n   = extra_q;
			size_n    = size_q;
			crc_n     = crc_q;
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bl_q    <= 3'd0;
			pos_q   <= '0;
			strat_q <= 1'b0;
			block_q <= 4'd0;
			rate_q  <= 4'd0;
			chan_q  <= 4'd0;
			depth_q <= 5'd0;
			extra_q <= '0;
			size_q  <= '0;
			crc_q   <= 8'd0;
		end else begin
			phase_q <= phase_n;
			bl_q    <= bl_n;
			pos_q   <= pos_n;
			strat_q <= strat_n;
			block_q <= block_n;
			rate_q  <= rate_n;
			chan_q  <= chan_n;
			depth_q <= depth_n;
			extra_q <= extra_n;
			size_q  <= size_n;
			crc_q   <= crc_n;
		end
	end

endmodule

// ----- sv/frame_header_parser.sv -----
// Frame header parser: input word register, parse step, result register.
// The byte that ends or breaks a header passes the input word register; its result is then
// registered. Throughput: one header byte per cycle; the parse step stalls only while the
// result register is held, and then only an empty input register takes a new word.
// Reset: arst_n clears the parse phase to waiting for a start byte and empties both registers.
// Depends on fhp_pkg, fhp_byte_if, fhp_result_if, fhp_parse.
module frame_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	fhp_byte_if.sink    byte_ch,
	fhp_result_if.source result_ch
);
	import fhp_pkg::*;

	logic       s1_valid_q;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       out_valid_q;
	result_t    res_q;
	logic       out_free;
	logic       advance;
	step_t      step;
	logic       res_valid;
	result_t    res;

	assign out_free      = !out_valid_q || result_ch.ready;
	assign advance       = s1_valid_q && out_free;
	assign byte_ch.ready = !s1_valid_q || advance;

	assign step.valid       = advance;
	assign step.start_req   = start_s1;
	assign step.header_byte = byte_s1;

	fhp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (byte_ch.valid && byte_ch.ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1  <= byte_ch.header_byte;
			start_s1 <= byte_ch.start_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign result_ch.valid              = out_valid_q;
	assign result_ch.status             = res_q.status;
	assign result_ch.variable_blocking  = res_q.variable_blocking;
	assign result_ch.position           = res_q.position;
	assign result_ch.block_size         = res_q.block_size;
	assign result_ch.sample_rate        = res_q.sample_rate;
	assign result_ch.channel_assignment = res_q.channel_assignment;
	assign result_ch.channel_count      = res_q.channel_count;
	assign result_ch.sample_depth       = res_q.sample_depth;

	assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ch.ready |-> s1_valid_q && out_valid_q)
		else $error("input stalled without a held result");

	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(byte_s1) && $stable(start_s1))
		else $error("stalled input word lost");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_ch.status != STS_OK |->
		result_ch.position == '0 && result_ch.block_size == '0 &&
		result_ch.sample_rate == '0 && result_ch.channel_count == '0)
		else $error("error result carries field data");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_ch.status == STS_OK |->
		result_ch.channel_count != '0 && result_ch.block_size != '0)
		else $error("ok result with empty block or channel count");

endmodule

// ----- tb/tb_frame_header_parser.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for frame_header_parser: directed and random header byte streams
// with random idling, checked word by word against an in-bench header decoder.
// Depends on fhp_pkg, fhp_byte_if, fhp_result_if and frame_header_parser.
module tb_frame_header_parser;
	import fhp_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 20;
	localparam int WORD_TARGET  = 550;
	localparam int HOLD_AT      = 22;
	localparam int HOLD_CYCLES  = 400;
	localparam int CALM_FROM    = 35;
	localparam int CALM_TO      = 50;
	localparam int TAIL_CYCLES  = 20;
	localparam int MAX_REPORTS  = 10;

	localparam logic [3:0] BLOCK_RESERVED = 4'd0;
	localparam logic [2:0] DEPTH_RSVD_A   = 3'd3;
	localparam logic [2:0] DEPTH_RSVD_B   = 3'd7;

	typedef struct {
		logic [7:0] b;
		logic       st;
		bit         drain_first;
		bit         no_gap;
	} hdr_word_t;

	typedef struct {
		bit        vb;
		bit [3:0]  bcode;
		bit [3:0]  rcode;
		bit [3:0]  chan;
		bit [2:0]  dcode;
		bit [35:0] pos;
		int        nbytes;
		bit [15:0] bsx;
		bit [15:0] rsx;
		bit        bad_crc;
		int        fix_at;
		bit [7:0]  fix_val;
		int        keep;
	} hdr_spec_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	fhp_byte_if   byte_ch();
	fhp_result_if result_ch();

	frame_header_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.result_ch(result_ch)
	);

	always #(CLK_HALF) clk = ~clk;

	// decoder state
	phase_t      ph = PH_IDLE;
	logic [2:0]  left;
	logic [35:0] pos_acc;
	logic        strat;
	logic [3:0]  bcode;
	logic [3:0]  rcode;
	logic [3:0]  chan;
	logic [4:0]  depth;
	logic [16:0] extra;
	logic [16:0] bsize;
	logic [7:0]  crc;

	result_t   expected_hdrs[$];
	hdr_word_t pending_words[$];
	hdr_word_t next_word;
	result_t   got;
	result_t   want;

	int words_sent = 0;
	int rx_count   = 0;
	int mismatches = 0;
	int cycles     = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;

	function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] r;
		r = c ^ b;
		repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
		return r;
	endfunction

	function automatic string show_result(input result_t r);
		return $sformatf("st=%0d vb=%0d pos=%h bs=%0d sr=%0d ca=%0d cc=%0d sd=%0d",
			r.status, r.variable_blocking, r.position, r.block_size, r.sample_rate,
			r.channel_assignment, r.channel_count, r.sample_depth);
	endfunction

	task automatic post_error(input logic [3:0] code);
		result_t r;
		r = '0;
		r.status = code;
		expected_hdrs.push_back(r);
		ph = PH_IDLE;
	endtask

	task automatic enter_rate_field();
		extra = '0;
		if (rcode == RATE_BAD) begin
			post_error(STS_RATE);
		end else if (rcode == RATE_KHZ) begin
			left = 3'd1;
			ph   = PH_RSX;
		end else if (rcode == RATE_HZ || rcode == RATE_DAHZ) begin
			left = 3'd2;
			ph   = PH_RSX;
		end else begin
			ph = PH_CRC;
		end
	endtask

	task automatic close_position();
		if (!strat && pos_acc[35:INDEX_BITS] != '0) begin
			post_error(STS_INDEX);
		end else if (bcode == BLOCK_RESERVED) begin
			post_error(STS_BLOCK);
		end else if (bcode == BLOCK_X8 || bcode == BLOCK_X16) begin
			extra = '0;
			left  = (bcode == BLOCK_X8) ? 3'd1 : 3'd2;
			ph    = PH_BSX;
		end else begin
			if (bcode >= 4'd8)
				bsize = 17'd256 << (bcode - 4'd8);
			else if (bcode == 4'd1)
				bsize = 17'd192;
			else
				bsize = 17'd576 << (bcode - 4'd2);
			enter_rate_field();
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic st);
		int      ones;
		result_t r;
		if (st) begin
			left    = '0;
			pos_acc = '0;
			strat   = 1'b0;
			bcode   = '0;
			rcode   = '0;
			chan    = '0;
			depth   = '0;
			bsize   = '0;
			extra   = {9'd0, b};
			crc     = crc_step(8'd0, b);
			ph      = PH_B1;
			return;
		end
		if (ph == PH_IDLE)
			return;
		if (ph != PH_CRC)
			crc = crc_step(crc, b);
		case (ph)
			PH_B1: begin
				if (extra != {9'd0, SYNC_FIRST} || b[7:2] != SYNC_SECOND) begin
					post_error(STS_SYNC);
				end else if (b[1]) begin
					post_error(STS_RESERVED);
				end else begin
					strat = b[0];
					ph    = PH_B2;
				end
			end
			PH_B2: begin
				bcode = b[7:4];
				rcode = b[3:0];
				ph    = PH_B3;
			end
			PH_B3: begin
				chan = b[7:4];
				if (chan > CHAN_MAX) begin
					post_error(STS_CHANNEL);
				end else if (b[3:1] == DEPTH_RSVD_A || b[3:1] == DEPTH_RSVD_B) begin
					post_error(STS_DEPTH);
				end else begin
					case (b[3:1])
						3'd1:    depth = 5'd8;
						3'd2:    depth = 5'd12;
						3'd4:    depth = 5'd16;
						3'd5:    depth = 5'd20;
						3'd6:    depth = 5'd24;
						default: depth = 5'd0;
					endcase
					if (b[0])
						post_error(STS_RESERVED);
					else
						ph = PH_POS;
				end
			end
			PH_POS: begin
				ones = 0;
				while (ones < 8 && b[7 - ones])
					ones++;
				if (ones == 0) begin
					pos_acc = {28'd0, b};
					close_position();
				end else if (ones == 1 || ones == 8) begin
					post_error(STS_CODED);
				end else begin
					pos_acc = {28'd0, b & (8'h7F >> ones)};
					left    = 3'(ones - 1);
					ph      = PH_POSC;
				end
			end
			PH_POSC: begin
				if (b[7:6] != 2'b10) begin
					post_error(STS_CODED);
				end else begin
					pos_acc = {pos_acc[29:0], b[5:0]};
					left    = left - 3'd1;
					if (left == 3'd0)
						close_position();
				end
			end
			PH_BSX: begin
				extra = {extra[8:0], b};
				left  = left - 3'd1;
				if (left == 3'd0) begin
					bsize = extra + 17'd1;
					enter_rate_field();
				end
			end
			PH_RSX: begin
				extra = {extra[8:0], b};
				left  = left - 3'd1;
				if (left == 3'd0)
					ph = PH_CRC;
			end
			PH_CRC: begin
				if (b != crc) begin
					post_error(STS_CRC);
				end else begin
					r.status            = STS_OK;
					r.variable_blocking = strat;
					r.position          = pos_acc;
					r.block_size        = bsize;
					case (rcode)
						RATE_KHZ:  r.sample_rate = 20'(32'(extra) * KHZ_SCALE);
						RATE_HZ:   r.sample_rate = 20'(extra);
						RATE_DAHZ: r.sample_rate = 20'(32'(extra) * DAHZ_SCALE);
						4'd1:      r.sample_rate = 20'd88200;
						4'd2:      r.sample_rate = 20'd176400;
						4'd3:      r.sample_rate = 20'd192000;
						4'd4:      r.sample_rate = 20'd8000;
						4'd5:      r.sample_rate = 20'd16000;
						4'd6:      r.sample_rate = 20'd22050;
						4'd7:      r.sample_rate = 20'd24000;
						4'd8:      r.sample_rate = 20'd32000;
						4'd9:      r.sample_rate = 20'd44100;
						4'd10:     r.sample_rate = 20'd48000;
						4'd11:     r.sample_rate = 20'd96000;
						default:   r.sample_rate = 20'd0;
					endcase
					r.channel_assignment = chan;
					r.channel_count      = (chan < CHAN_STEREO) ? chan + 4'd1 : 4'd2;
					r.sample_depth       = depth;
					expected_hdrs.push_back(r);
					ph = PH_IDLE;
				end
			end
			default: ph = PH_IDLE;
		endcase
	endtask

	function automatic hdr_spec_t plain_spec();
		hdr_spec_t s;
		s.vb      = 1'b0;
		s.bcode   = 4'd8;
		s.rcode   = 4'd9;
		s.chan    = 4'd1;
		s.dcode   = 3'd4;
		s.pos     = 36'd5;
		s.nbytes  = 1;
		s.bsx     = '0;
		s.rsx     = '0;
		s.bad_crc = 1'b0;
		s.fix_at  = -1;
		s.fix_val = '0;
		s.keep    = 99;
		return s;
	endfunction

	function automatic hdr_spec_t random_spec();
		hdr_spec_t s;
		int        v;
		int        bits;
		s        = plain_spec();
		s.vb     = 1'($urandom_range(1));
		s.bcode  = ($urandom_range(99) < 4) ? BLOCK_RESERVED : 4'($urandom_range(15, 1));
		s.rcode  = ($urandom_range(99) < 4) ? RATE_BAD : 4'($urandom_range(14));
		s.chan   = ($urandom_range(99) < 4) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
		v        = $urandom_range(5);
		s.dcode  = 3'(v < 3 ? v : v + 1);
		if ($urandom_range(99) < 4)
			s.dcode = $urandom_range(1) ? DEPTH_RSVD_A : DEPTH_RSVD_B;
		if (s.vb)
			s.nbytes = $urandom_range(7, 1);
		else
			s.nbytes = ($urandom_range(99) < 5) ? 7 : $urandom_range(6, 1);
		bits    = (s.nbytes == 1) ? 7 : 5 * s.nbytes + 1;
		s.pos   = 36'({$urandom, $urandom}) & ~(36'hF_FFFF_FFFF << bits);
		s.bsx   = 16'($urandom);
		s.rsx   = 16'($urandom);
		s.bad_crc = ($urandom_range(99) < 5);
		return s;
	endfunction

	task automatic queue_header(input hdr_spec_t s, input bit drain_first, input bit no_gap);
		logic [7:0] h[$];
		logic [7:0] c;
		int         k;
		hdr_word_t  w;
		h.push_back(SYNC_FIRST);
		h.push_back({SYNC_SECOND, 1'b0, s.vb});
		h.push_back({s.bcode, s.rcode});
		h.push_back({s.chan, s.dcode, 1'b0});
		if (s.nbytes == 1) begin
			h.push_back({1'b0, s.pos[6:0]});
		end else begin
			c = 8'hFF << (8 - s.nbytes);
			c = c | (8'(s.pos >> (6 * (s.nbytes - 1))) & (8'h7F >> s.nbytes));
			h.push_back(c);
			for (k = s.nbytes - 2; k >= 0; k--)
				h.push_back({2'b10, 6'(s.pos >> (6 * k))});
		end
		if (s.bcode == BLOCK_X8) begin
			h.push_back(s.bsx[7:0]);
		end else if (s.bcode == BLOCK_X16) begin
			h.push_back(s.bsx[15:8]);
			h.push_back(s.bsx[7:0]);
		end
		if (s.rcode == RATE_KHZ) begin
			h.push_back(s.rsx[7:0]);
		end else if (s.rcode == RATE_HZ || s.rcode == RATE_DAHZ) begin
			h.push_back(s.rsx[15:8]);
			h.push_back(s.rsx[7:0]);
		end
		c = 8'd0;
		foreach (h[i])
			c = crc_step(c, h[i]);
		if (s.bad_crc)
			c = c ^ 8'($urandom_range(255, 1));
		h.push_back(c);
		if (s.fix_at >= 0 && s.fix_at < h.size())
			h[s.fix_at] = s.fix_val;
		for (k = 0; k < h.size() && k < s.keep; k++) begin
			w.b           = h[k];
			w.st          = (k == 0);
			w.drain_first = drain_first && (k == 0);
			w.no_gap      = no_gap;
			pending_words.push_back(w);
		end
	endtask

	task automatic queue_noise(input int n);
		hdr_word_t w;
		repeat (n) begin
			w.b           = 8'($urandom);
			w.st          = 1'b0;
			w.drain_first = 1'b0;
			w.no_gap      = 1'b0;
			pending_words.push_back(w);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			byte_ch.valid       <= 1'b0;
			byte_ch.header_byte <= 8'd0;
			byte_ch.start_req   <= 1'b0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				parse_byte(byte_ch.header_byte, byte_ch.start_req);
				words_sent++;
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				if (pending_words.size() != 0 &&
						!(pending_words[0].drain_first && expected_hdrs.size() != 0) &&
						(pending_words[0].no_gap || $urandom_range(99) >= IDLE_PCT)) begin
					next_word = pending_words.pop_front();
					byte_ch.valid       <= 1'b1;
					byte_ch.header_byte <= next_word.b;
					byte_ch.start_req   <= next_word.st;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (rx_count == HOLD_AT && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				rx_count <= rx_count + 1;
				got.status             = result_ch.status;
				got.variable_blocking  = result_ch.variable_blocking;
				got.position           = result_ch.position;
				got.block_size         = result_ch.block_size;
				got.sample_rate        = result_ch.sample_rate;
				got.channel_assignment = result_ch.channel_assignment;
				got.channel_count      = result_ch.channel_count;
				got.sample_depth       = result_ch.sample_depth;
				if (expected_hdrs.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result word: %s", show_result(got));
				end else begin
					want = expected_hdrs.pop_front();
					if (got.status !== want.status ||
							got.variable_blocking !== want.variable_blocking ||
							got.position !== want.position ||
							got.block_size !== want.block_size ||
							got.sample_rate !== want.sample_rate ||
							got.channel_assignment !== want.channel_assignment ||
							got.channel_count !== want.channel_count ||
							got.sample_depth !== want.sample_depth) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("mismatch on result word %0d", rx_count);
							$display("  expected %s", show_result(want));
							$display("  actual   %s", show_result(got));
						end
					end
				end
			end
			result_ch.ready <= (hold_left == 0) &&
				((rx_count >= CALM_FROM && rx_count < CALM_TO) ||
				$urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				expected_hdrs.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		hdr_spec_t s;
		int        n_hdr;
		int        kind;

		// widest header: 16-bit block size, rate in 10 Hz units, 7-byte position
		s = plain_spec();
		s.vb = 1'b1;
		s.bcode = BLOCK_X16;
		s.bsx = 16'hFFFF;
		s.rcode = RATE_DAHZ;
		s.rsx = 16'hFFFF;
		s.chan = CHAN_MAX;
		s.dcode = 3'd6;
		s.pos = '1;
		s.nbytes = 7;
		queue_header(s, 1'b0, 1'b0);
		s = plain_spec();
		s.bcode = 4'd1;
		s.rcode = 4'd0;
		s.chan = 4'd0;
		s.dcode = 3'd0;
		s.pos = '0;
		queue_header(s, 1'b0, 1'b0);
		s = plain_spec();
		s.bcode = BLOCK_X8;
		s.rcode = RATE_KHZ;
		s.rsx = 16'h00FF;
		s.chan = CHAN_STEREO;
		queue_header(s, 1'b0, 1'b0);
		s = plain_spec();
		s.vb = 1'b1;
		s.rcode = RATE_HZ;
		s.rsx = 16'hFFFF;
		s.chan = 4'd9;
		s.nbytes = 2;
		s.pos = 36'h7FF;
		queue_header(s, 1'b0, 1'b0);
		// bytes while waiting
		queue_noise(3);
		// sync error on either byte, reserved bit in the second byte
		s = plain_spec();
		s.fix_at = 0;
		s.fix_val = 8'hFE;
		s.keep = 2;
		queue_header(s, 1'b0, 1'b0);
		s.fix_at = 1;
		s.fix_val = 8'hFC;
		queue_header(s, 1'b0, 1'b0);
		s.fix_val = 8'hFA;
		queue_header(s, 1'b0, 1'b0);
		s = plain_spec();
		s.chan = 4'd11;
		s.keep = 4;
		queue_header(s, 1'b0, 1'b0);
		s = plain_spec();
		s.dcode = DEPTH_RSVD_A;
		s.keep = 4;
		queue_header(s, 1'b0, 1'b0);
		s = plain_spec();
		s.fix_at = 3;
		s.fix_val = {4'd2, 3'd1, 1'b1};
		s.keep = 4;
		queue_header(s, 1'b0, 1'b0);
		// malformed coded numbers
		s = plain_spec();
		s.fix_at = 4;
		s.fix_val = 8'h80;
		s.keep = 5;
		queue_header(s, 1'b0, 1'b0);
		s.fix_val = 8'hFF;
		queue_header(s, 1'b0, 1'b0);
		s = plain_spec();
		s.nbytes = 3;
		s.fix_at = 5;
		s.fix_val = 8'hC0;
		s.keep = 6;
		queue_header(s, 1'b0, 1'b0);
		s = plain_spec();
		s.nbytes = 7;
		s.pos = 36'h0_8000_0000;
		queue_header(s, 1'b0, 1'b0);
		s = plain_spec();
		s.bcode = BLOCK_RESERVED;
		queue_header(s, 1'b0, 1'b0);
		s = plain_spec();
		s.rcode = RATE_BAD;
		queue_header(s, 1'b0, 1'b0);
		s = plain_spec();
		s.bad_crc = 1'b1;
		queue_header(s, 1'b0, 1'b0);
		// abandon a header with a new start byte
		s = plain_spec();
		s.keep = 4;
		queue_header(s, 1'b0, 1'b0);
		queue_header(plain_spec(), 1'b1, 1'b0);

		n_hdr = 0;
		while (pending_words.size() < WORD_TARGET) begin
			s = random_spec();
			kind = $urandom_range(99);
			if (kind < 12) begin
				s.fix_at = $urandom_range(s.nbytes + 6);
				s.fix_val = 8'($urandom);
			end else if (kind < 20) begin
				s.keep = $urandom_range(7, 1);
			end
			queue_header(s, n_hdr % 16 == 8, n_hdr >= 24 && n_hdr < 36);
			if ($urandom_range(99) < 10)
				queue_noise($urandom_range(4, 1));
			n_hdr++;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || byte_ch.valid)
			@(negedge clk);
		while (expected_hdrs.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d header bytes (%0d random headers), %0d results checked.",
			words_sent, n_hdr, rx_count);
		$display("Stimulus mixed clean headers, every error status, truncation, noise and stalls.");
		if (mismatches == 0 && expected_hdrs.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
